// File: design/uart_register_block_with_fifos_defines.svh
// Assertion macros used by the checker file.
`ifndef UART_REGISTER_BLOCK_WITH_FIFOS_DEFINES_SVH
`define UART_REGISTER_BLOCK_WITH_FIFOS_DEFINES_SVH

// a holds at an edge, so b holds at the same edge
`define URBF_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: a implies b");

// a holds at an edge, so b holds at the next edge
`define URBF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: a implies b next cycle");

`endif

// File: design/urbf_pkg.sv
// Types, register codes and constants of the UART register block.
package urbf_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    localparam logic [7:0] LCR_RESET    = 8'h03;
    localparam int         LCR_DLAB_BIT = 7;
    localparam int         IER_RX_BIT   = 0;
    localparam int         IER_TX_BIT   = 1;
    localparam int         FCR_EN_BIT   = 0;
    localparam logic [7:0] MCR_LOOP     = 8'h10;
    localparam logic [7:0] IIR_RX_DATA  = 8'h04;
    localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
    localparam logic [7:0] IIR_NONE     = 8'h01;
    localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
    localparam logic [7:0] LSR_RX_READY = 8'h01;
    localparam logic [7:0] MSR_VALUE    = 8'hB0;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_RX_BYTE = 2'd2,
        ACT_TX_TAKE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_DATA = 3'd0,
        REG_IER  = 3'd1,
        REG_IIR  = 3'd2,
        REG_LCR  = 3'd3,
        REG_MCR  = 3'd4,
        REG_LSR  = 3'd5,
        REG_MSR  = 3'd6,
        REG_SCR  = 3'd7
    } reg_offset_t;

    typedef enum logic [1:0] {
        FLT_NONE       = 2'd0,
        FLT_RX_EMPTY   = 2'd1,
        FLT_TX_FULL    = 2'd2,
        FLT_RX_OVERRUN = 2'd3
    } fault_t;

    typedef struct packed {
        action_t     action;
        reg_offset_t reg_offset;
        logic [7:0]  write_data;
        logic [7:0]  line_rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       line_tx_valid;
        logic [7:0] line_tx_byte;
        fault_t     fault;
    } result_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// File: design/urbf_if.sv
// Valid/ready channel interfaces for input words and result words.
interface urbf_item_if import urbf_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface urbf_result_if import urbf_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/urbf_ctrl.sv
// Controller: sequences capture and execute of one word, owns result valid.
module urbf_ctrl
    import urbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    output logic      result_valid,
    input  logic      result_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready  = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_EXEC:
            begin
                // output slot free or emptied this cycle
                cmd.execute = !out_valid_reg || result_ready;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: design/urbf_datapath.sv
// Datapath: byte registers, rx/tx FIFO stores and the result register.
module urbf_datapath
    import urbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    input  item_t     item_payload,
    output result_t   result_payload
);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    item_t   item_reg;
    result_t result_reg, result_next;
    logic [7:0] rx_rd_reg, tx_rd_reg;

    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] scr_reg, scr_next;

    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;

    logic rx_push, rx_pop, tx_push, tx_pop;
    logic dlab, rx_any, tx_empty, rx_full, tx_full;

    assign dlab     = lcr_reg[LCR_DLAB_BIT];
    assign rx_any   = (rx_count_reg != '0);
    assign tx_empty = (tx_count_reg == '0);
    assign rx_full  = (rx_count_reg == RX_CW'(RX_DEPTH));
    assign tx_full  = (tx_count_reg == TX_CW'(TX_DEPTH));

    always_comb
    begin
        lcr_next = lcr_reg;
        ier_next = ier_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        fcr_next = fcr_reg;
        mcr_next = mcr_reg;
        scr_next = scr_reg;
        rx_push  = 1'b0;
        rx_pop   = 1'b0;
        tx_push  = 1'b0;
        tx_pop   = 1'b0;
        result_next = '{read_data: 8'h00, irq_level: 1'b0, line_tx_valid: 1'b0,
                        line_tx_byte: 8'h00, fault: FLT_NONE};

        unique case (item_reg.action)
            ACT_READ:
            begin
                unique case (item_reg.reg_offset)
                    REG_DATA:
                    begin
                        if (dlab)
                            result_next.read_data = dll_reg;
                        else if (!rx_any)
                            result_next.fault = FLT_RX_EMPTY;
                        else
                        begin
                            result_next.read_data = rx_rd_reg;
                            rx_pop = 1'b1;
                        end
                    end
                    REG_IER: result_next.read_data = dlab ? dlm_reg : ier_reg;
                    REG_IIR:
                    begin
                        if (ier_reg[IER_RX_BIT] && rx_any)
                            result_next.read_data = IIR_RX_DATA;
                        else if (ier_reg[IER_TX_BIT] && tx_empty)
                            result_next.read_data = IIR_TX_EMPTY;
                        else
                            result_next.read_data = IIR_NONE;
                        if (fcr_reg[FCR_EN_BIT])
                            result_next.read_data = result_next.read_data | IIR_FIFO_ON;
                    end
                    REG_LCR: result_next.read_data = lcr_reg;
                    REG_MCR: result_next.read_data = mcr_reg;
                    REG_LSR:
                        result_next.read_data = (tx_empty ? LSR_TX_EMPTY : 8'h00)
                                              | (rx_any ? LSR_RX_READY : 8'h00);
                    REG_MSR: result_next.read_data = MSR_VALUE;
                    REG_SCR: result_next.read_data = scr_reg;
                    default: ;
                endcase
            end
            ACT_WRITE:
            begin
                unique case (item_reg.reg_offset)
                    REG_DATA:
                    begin
                        if (dlab)
                            dll_next = item_reg.write_data;
                        else if (tx_full)
                            result_next.fault = FLT_TX_FULL;
                        else
                            tx_push = 1'b1;
                    end
                    REG_IER:
                    begin
                        if (dlab)
                            dlm_next = item_reg.write_data;
                        else
                            ier_next = item_reg.write_data;
                    end
                    REG_IIR: fcr_next = item_reg.write_data;
                    REG_LCR: lcr_next = item_reg.write_data;
                    REG_MCR: mcr_next = item_reg.write_data & ~MCR_LOOP;
                    REG_SCR: scr_next = item_reg.write_data;
                    REG_LSR, REG_MSR: ;
                    default: ;
                endcase
            end
            ACT_RX_BYTE:
            begin
                if (rx_full)
                    result_next.fault = FLT_RX_OVERRUN;
                else
                    rx_push = 1'b1;
            end
            ACT_TX_TAKE:
            begin
                if (!tx_empty)
                begin
                    result_next.line_tx_valid = 1'b1;
                    result_next.line_tx_byte  = tx_rd_reg;
                    tx_pop = 1'b1;
                end
            end
            default: ;
        endcase

        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        if (rx_pop)
        begin
            rx_head_next  = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
            rx_count_next = rx_count_reg - 1'b1;
        end
        if (rx_push)
        begin
            rx_tail_next  = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + 1'b1;
            rx_count_next = rx_count_reg + 1'b1;
        end
        if (tx_pop)
        begin
            tx_head_next  = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
            tx_count_next = tx_count_reg - 1'b1;
        end
        if (tx_push)
        begin
            tx_tail_next  = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + 1'b1;
            tx_count_next = tx_count_reg + 1'b1;
        end

        // level interrupt reflects the state after this word
        result_next.irq_level = (ier_next[IER_RX_BIT] && (rx_count_next != '0))
                             || (ier_next[IER_TX_BIT] && (tx_count_next == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcr_reg      <= LCR_RESET;
            ier_reg      <= '0;
            dll_reg      <= '0;
            dlm_reg      <= '0;
            fcr_reg      <= '0;
            mcr_reg      <= '0;
            scr_reg      <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            lcr_reg      <= lcr_next;
            ier_reg      <= ier_next;
            dll_reg      <= dll_next;
            dlm_reg      <= dlm_next;
            fcr_reg      <= fcr_next;
            mcr_reg      <= mcr_next;
            scr_reg      <= scr_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
        end
    end

    // word capture and FIFO head reads happen together
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg  <= item_payload;
            rx_rd_reg <= rx_mem[rx_head_reg];
            tx_rd_reg <= tx_mem[tx_head_reg];
        end
        if (cmd.execute)
            result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && rx_push)
            rx_mem[rx_tail_reg] <= item_reg.line_rx_byte;
        if (cmd.execute && tx_push)
            tx_mem[tx_tail_reg] <= item_reg.write_data;
    end

    assign result_payload = result_reg;

endmodule

// File: design/uart_register_block_with_fifos.sv
// Top level of the 16550-style UART register block with rx/tx FIFOs.
//
//  channel   dir   payload                                             handshake
//  item      in    action, reg_offset, write_data, line_rx_byte        valid/ready
//  result    out   read_data, irq_level, line_tx_valid, line_tx_byte,  valid/ready
//                  fault
//
// Each word is handled in order: first it is registered and both FIFO heads are read from
// their stores, then registers and FIFOs update and the result register is loaded.
// The next word is taken while a result waits; execution then holds until it leaves.
// rst_n resets all control, the byte registers (LCR to 8'h03, the rest to zero) and the FIFO pointers at once.
module uart_register_block_with_fifos
    import urbf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    urbf_item_if.sink     item,
    urbf_result_if.source result
);

    ctrl_cmd_t cmd;

    urbf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    urbf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item_payload   (item.payload),
        .result_payload (result.payload)
    );

endmodule

// File: design/urbf_checker.sv
// Port-level checker for the UART register block, bound to the top level.
`include "uart_register_block_with_fifos_defines.svh"

module urbf_checker
    import urbf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_payload
);

    `URBF_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && !result_ready, result_valid)
    `URBF_ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, item_valid && item_ready, !item_ready)
    `URBF_ASSERT_SAME(a_tx_word_clean, clk, rst_n, result_valid && result_payload.line_tx_valid,
        result_payload.fault == FLT_NONE && result_payload.read_data == 8'h00)
    `URBF_ASSERT_SAME(a_empty_read_zero, clk, rst_n,
        result_valid && result_payload.fault == FLT_RX_EMPTY,
        result_payload.read_data == 8'h00 && !result_payload.line_tx_valid)

endmodule

bind uart_register_block_with_fifos urbf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
